### rtl/core/particle_bounce_step_defines.svh
// Assertion macros shared by the particle update block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PARTICLE_BOUNCE_STEP_DEFINES_SVH
`define PARTICLE_BOUNCE_STEP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PBS_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pbs_pkg.sv
// Shared types and constants of the particle update block.
// Depends on nothing; every module and interface imports it.
package pbs_pkg;

    // Field widths of the channels and of the stored state.
    localparam int CNT_W     = 7;
    localparam int DT_W      = 11;
    localparam int VAL_W     = 16;
    localparam int IDX_OUT_W = 6;
    localparam int Q_DEPTH   = 2;

    // Command codes on the input channel.
    localparam logic OP_INIT = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Largest time step after clamping.
    localparam logic [DT_W-1:0] DT_MAX = 11'd1638;

    // Reset value of the particle count register.
    localparam logic [CNT_W-1:0] PCOUNT_RESET = 7'd1;

    // One classified command passed from the front to the back.
    typedef struct packed {
        logic             is_init;
        logic [DT_W-1:0]  dt;
        logic [CNT_W-1:0] count;
    } t_cmd;

endpackage

### rtl/core/pbs_cmd_if.sv
// Command channel of the particle update block: opcode and time step.
// Depends on pbs_pkg for the field widths.
interface pbs_cmd_if import pbs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic signed [VAL_W-1:0] step_time;

    modport source (output valid, output opcode, output step_time, input ready);
    modport sink   (input valid, input opcode, input step_time, output ready);
endinterface

### rtl/core/pbs_res_if.sv
// Result channel of the particle update block: one particle position per item.
// Depends on pbs_pkg for the field widths.
interface pbs_res_if import pbs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_OUT_W-1:0]    particle_index;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic                    last;

    modport source (output valid, output particle_index, output pos_x, output pos_y,
                    output last, input ready);
    modport sink   (input valid, input particle_index, input pos_x, input pos_y,
                    input last, output ready);
endinterface

### rtl/core/pbs_front.sv
// Front end: accepts commands, holds the count register, classifies each item.
// Depends on pbs_pkg and pbs_cmd_if.
module pbs_front import pbs_pkg::*; #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    pbs_cmd_if.sink          i_cmd,
    output logic             o_push,
    output t_cmd             o_push_cmd,
    input  logic             i_q_ready
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

    logic [CNT_W-1:0] r_pcount;
    logic [CNT_W-1:0] r_active;
    logic             r_init;
    logic             accept;
    logic [CNT_W-1:0] init_count;
    logic [DT_W-1:0]  dt_clamped;

    assign i_cmd.ready = i_q_ready;
    assign accept      = i_cmd.valid && i_q_ready;

    // Count for a new init: zero means one, saturate at the array depth.
    always_comb begin
        if (r_pcount == '0) begin
            init_count = CNT_W'(1);
        end else if (r_pcount > MAX_CNT) begin
            init_count = MAX_CNT;
        end else begin
            init_count = r_pcount;
        end
    end

    // Clamp the time step to the allowed range.
    always_comb begin
        if (i_cmd.step_time[VAL_W-1]) begin
            dt_clamped = '0;
        end else if (i_cmd.step_time > $signed({5'b0, DT_MAX})) begin
            dt_clamped = DT_MAX;
        end else begin
            dt_clamped = i_cmd.step_time[DT_W-1:0];
        end
    end

    // A step before the first init produces no work and is dropped here.
    always_comb begin
        o_push_cmd = '0;
        o_push     = 1'b0;
        if (i_cmd.opcode == OP_INIT) begin
            o_push_cmd.is_init = 1'b1;
            o_push_cmd.count   = init_count;
            o_push             = accept;
        end else begin
            o_push_cmd.dt    = dt_clamped;
            o_push_cmd.count = r_active;
            o_push           = accept && r_init;
        end
    end

    // Count register and the particle population known to the front.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= PCOUNT_RESET;
            r_active <= '0;
            r_init   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pcount <= i_cfg_wdata;
            end
            if (accept && i_cmd.opcode == OP_INIT) begin
                r_active <= init_count;
                r_init   <= 1'b1;
            end
        end
    end

endmodule

### rtl/core/pbs_queue.sv
// Two-entry command queue between the front end and the particle engine.
// Depends on pbs_pkg and the assertion macro header.
`include "particle_bounce_step_defines.svh"
module pbs_queue import pbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_slot [Q_DEPTH];
    logic          r_wptr;
    logic          r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

    `PBS_ASSERT(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(Q_DEPTH), "queue overfilled")

endmodule

### rtl/core/pbs_back.sv
// Particle engine: walks the stored particles for one command at a time,
// drawing new values for an init or integrating and bouncing for a step.
// Depends on pbs_pkg, pbs_res_if and the assertion macro header.
`include "particle_bounce_step_defines.svh"
module pbs_back import pbs_pkg::*; #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    pbs_res_if.source o_res
);

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int PRD_W = 40;
    localparam int MUL_W = VAL_W + DT_W + 1;

    localparam logic [31:0]             RNG_SEED = 32'h1234_5678;
    localparam logic signed [VAL_W:0]   POS_LOW  = -17'sd31130;
    localparam logic signed [VAL_W:0]   VEL_LOW  = -17'sd11469;
    localparam logic [VAL_W-1:0]        POS_SPAN = 16'd62259;
    localparam logic [VAL_W-1:0]        VEL_SPAN = 16'd22938;
    localparam logic signed [VAL_W:0]   WALL     = 17'sd32113;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_back_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos;
        logic signed [VAL_W-1:0] vel;
    } t_axis;

    // One xorshift32 step (shifts 13, 17, 5).
    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    // Low bound plus the top bits of the scaled fraction.
    function automatic logic signed [VAL_W-1:0] draw(input logic signed [VAL_W:0] low,
                                                     input logic [PRD_W-1:0] prod);
        logic signed [VAL_W:0] sum;
        sum = low + $signed({1'b0, prod[PRD_W-1:PRD_W-VAL_W]});
        return sum[VAL_W-1:0];
    endfunction

    // Add the floored move, clamp at the wall and reflect the velocity.
    function automatic t_axis move_axis(input logic signed [VAL_W-1:0] pos,
                                        input logic signed [VAL_W-1:0] vel,
                                        input logic signed [MUL_W-1:0] prod);
        logic signed [VAL_W:0] delta;
        logic signed [VAL_W:0] sum;
        t_axis                 res;
        delta   = (VAL_W + 1)'($signed(prod[MUL_W-1:15]));
        sum     = (VAL_W + 1)'(pos) + delta;
        res.vel = vel;
        res.pos = sum[VAL_W-1:0];
        if (sum < -WALL) begin
            res.pos = -WALL[VAL_W-1:0];
            res.vel = -vel;
        end else if (sum > WALL) begin
            res.pos = WALL[VAL_W-1:0];
            res.vel = -vel;
        end
        return res;
    endfunction

    t_back_state r_state;
    t_cmd        r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [31:0] r_rng;
    logic        adv;
    logic        issue;
    logic        issue_last;
    logic [31:0] rnd [4];

    // Particle store.
    logic signed [VAL_W-1:0] r_mem_px [MAX_PARTICLES];
    logic signed [VAL_W-1:0] r_mem_py [MAX_PARTICLES];
    logic signed [VAL_W-1:0] r_mem_vx [MAX_PARTICLES];
    logic signed [VAL_W-1:0] r_mem_vy [MAX_PARTICLES];

    // Stage 1: read data or random fractions.
    logic             r_p1_valid;
    logic [IDX_W-1:0] r_p1_idx;
    logic             r_p1_last;
    logic             r_p1_init;
    logic [23:0]      r_p1_frac [4];
    logic signed [VAL_W-1:0] r_rd_px;
    logic signed [VAL_W-1:0] r_rd_py;
    logic signed [VAL_W-1:0] r_rd_vx;
    logic signed [VAL_W-1:0] r_rd_vy;

    // Stage 2: products.
    logic             r_p2_valid;
    logic [IDX_W-1:0] r_p2_idx;
    logic             r_p2_last;
    logic             r_p2_init;
    logic [PRD_W-1:0] r_p2_prod [4];
    logic signed [MUL_W-1:0] r_p2_mx;
    logic signed [MUL_W-1:0] r_p2_my;
    logic signed [VAL_W-1:0] r_p2_px;
    logic signed [VAL_W-1:0] r_p2_py;
    logic signed [VAL_W-1:0] r_p2_vx;
    logic signed [VAL_W-1:0] r_p2_vy;

    // Stage 3: output register.
    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_idx;
    logic             r_o_last;
    logic signed [VAL_W-1:0] r_o_x;
    logic signed [VAL_W-1:0] r_o_y;

    t_axis new_x;
    t_axis new_y;
    logic signed [VAL_W-1:0] wr_px;
    logic signed [VAL_W-1:0] wr_py;
    logic signed [VAL_W-1:0] wr_vx;
    logic signed [VAL_W-1:0] wr_vy;

    // The whole pipe moves whenever the output register can take a new item.
    assign adv        = !r_o_valid || o_res.ready;
    assign issue      = (r_state == S_RUN);
    assign issue_last = (CNT_W'(r_idx) == r_cmd.count - CNT_W'(1));
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;

    // Four consecutive draws per particle, in the order x, y, vx, vy.
    assign rnd[0] = xorshift(r_rng);
    assign rnd[1] = xorshift(rnd[0]);
    assign rnd[2] = xorshift(rnd[1]);
    assign rnd[3] = xorshift(rnd[2]);

    // Sequencer: take a command, issue each particle, wait for the pipe to empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_rng   <= RNG_SEED;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_idx   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (adv) begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (r_cmd.is_init) begin
                            r_rng <= rnd[3];
                        end
                        if (issue_last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_valid && !r_p2_valid) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Command latch.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    // Valid bits of the pipe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            r_o_valid  <= r_p2_valid;
        end
    end

    // Stage 1: registered memory read, or the random fractions for an init.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_idx  <= r_idx;
            r_p1_last <= issue_last;
            r_p1_init <= r_cmd.is_init;
            for (int k = 0; k < 4; k++) begin
                r_p1_frac[k] <= rnd[k][23:0];
            end
            if (issue && !r_cmd.is_init) begin
                r_rd_px <= r_mem_px[r_idx];
                r_rd_py <= r_mem_py[r_idx];
                r_rd_vx <= r_mem_vx[r_idx];
                r_rd_vy <= r_mem_vy[r_idx];
            end
        end
    end

    // Stage 2: span scaling for init lanes, velocity times step for step lanes.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_idx     <= r_p1_idx;
            r_p2_last    <= r_p1_last;
            r_p2_init    <= r_p1_init;
            r_p2_prod[0] <= PRD_W'(POS_SPAN) * PRD_W'(r_p1_frac[0]);
            r_p2_prod[1] <= PRD_W'(POS_SPAN) * PRD_W'(r_p1_frac[1]);
            r_p2_prod[2] <= PRD_W'(VEL_SPAN) * PRD_W'(r_p1_frac[2]);
            r_p2_prod[3] <= PRD_W'(VEL_SPAN) * PRD_W'(r_p1_frac[3]);
            r_p2_mx      <= r_rd_vx * $signed({1'b0, r_cmd.dt});
            r_p2_my      <= r_rd_vy * $signed({1'b0, r_cmd.dt});
            r_p2_px      <= r_rd_px;
            r_p2_py      <= r_rd_py;
            r_p2_vx      <= r_rd_vx;
            r_p2_vy      <= r_rd_vy;
        end
    end

    // Stage 3 results: new particle for an init, moved particle for a step.
    assign new_x = move_axis(r_p2_px, r_p2_vx, r_p2_mx);
    assign new_y = move_axis(r_p2_py, r_p2_vy, r_p2_my);

    always_comb begin
        if (r_p2_init) begin
            wr_px = draw(POS_LOW, r_p2_prod[0]);
            wr_py = draw(POS_LOW, r_p2_prod[1]);
            wr_vx = draw(VEL_LOW, r_p2_prod[2]);
            wr_vy = draw(VEL_LOW, r_p2_prod[3]);
        end else begin
            wr_px = new_x.pos;
            wr_py = new_y.pos;
            wr_vx = new_x.vel;
            wr_vy = new_y.vel;
        end
    end

    // Write back to the store and load the output register.
    always_ff @(posedge i_clk) begin
        if (adv && r_p2_valid) begin
            r_mem_px[r_p2_idx] <= wr_px;
            r_mem_py[r_p2_idx] <= wr_py;
            r_mem_vx[r_p2_idx] <= wr_vx;
            r_mem_vy[r_p2_idx] <= wr_vy;
        end
        if (adv) begin
            r_o_idx  <= r_p2_idx;
            r_o_last <= r_p2_last;
            r_o_x    <= wr_px;
            r_o_y    <= wr_py;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.particle_index = IDX_OUT_W'(r_o_idx);
    assign o_res.pos_x          = r_o_x;
    assign o_res.pos_y          = r_o_y;
    assign o_res.last           = r_o_last;

    `PBS_ASSERT(a_idle_empty, i_clk, i_rst_n, r_state == S_IDLE, !r_p1_valid && !r_p2_valid, "pipe busy while idle")
    `PBS_ASSERT(a_idx_range, i_clk, i_rst_n, r_state == S_RUN, CNT_W'(r_idx) < r_cmd.count, "particle index past count")
    `PBS_ASSERT_NEXT(a_rng_nonzero, i_clk, i_rst_n, 1'b1, r_rng != '0, "random state collapsed to zero")

endmodule

### rtl/core/particle_bounce_step.sv
// Particle update block: Euler step of stored particles with wall bounce.
// Usage:
//   i_cmd carries one command item: opcode (init or step) and step_time.
//   i_cfg_we / i_cfg_wdata write the particle count used by the next init;
//   write it only while the block is idle.
//   o_res returns one item per active particle in index order, with last
//   set on the final one. An init reports the fresh positions, a step the
//   moved positions. A step before any init is accepted and reports nothing.
// Timing:
//   One particle enters the three-stage engine per cycle while o_res does
//   not stall, and the engine drains before the next command so that its
//   reads see the stored results. A command's first result goes through
//   the queue, the sequencer and the engine stages on its way to o_res.
//   A two-entry command queue lets new commands in while the engine works.
// Reset (synchronous, i_rst_n low): no particles, random seed reloaded,
//   particle count register back to one, queue and pipe emptied.
// Stalls: while o_res.valid is high and o_res.ready is low, the result
//   register and engine hold; commands are taken until the queue is full.
// Depends on pbs_pkg, the channel interfaces and the submodules.
module particle_bounce_step import pbs_pkg::*; #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    pbs_cmd_if.sink          i_cmd,
    pbs_res_if.source        o_res
);

    logic push;
    t_cmd push_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // Command classification and count register.
    pbs_front #(
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (i_cmd),
        .o_push     (push),
        .o_push_cmd (push_cmd),
        .i_q_ready  (q_ready)
    );

    // Decoupling queue.
    pbs_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_cmd(push_cmd),
        .o_ready   (q_ready),
        .o_valid   (q_valid),
        .o_cmd     (q_cmd),
        .i_pop     (q_pop)
    );

    // Particle engine and result register.
    pbs_back #(
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_cmd  (q_cmd),
        .o_q_pop  (q_pop),
        .o_res    (o_res)
    );

endmodule
